// ===== rtl/core/mmp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmp_pkg
// Types, codes and scaling helpers shared by the MIDI message parser.
// ----------------------------------------------------------------------------
package mmp_pkg;

  // Recognized status bytes and limits
  localparam logic [7:0] ST_NOTE   = 8'h90;
  localparam logic [7:0] ST_CTRL   = 8'hB0;
  localparam logic [7:0] ST_PITCH  = 8'hE0;
  localparam logic [7:0] NOTE_MAX  = 8'd124;
  localparam logic [7:0] CC_MOD    = 8'd1;
  localparam logic [7:0] CC_VOLUME = 8'd7;
  localparam logic [7:0] PITCH_D1  = 8'd0;

  // Request types
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MOD_MODE   = 2'd0,
    CFG_LOOPER_EN  = 2'd1,
    CFG_HOLD_TICKS = 2'd2
  } cfg_index_t;

  // Reset values
  localparam logic [7:0] VOLUME_RST = 8'd120;
  localparam logic [7:0] PITCH_RST  = 8'd64;
  localparam logic [6:0] HOLD_RST   = 7'd90;

  // Result event codes
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_ATTACK  = 3'd1,
    EV_RELEASE = 3'd2,
    EV_MOD     = 3'd3,
    EV_VOLUME  = 3'd4,
    EV_PITCH   = 3'd5,
    EV_LOOPER  = 3'd6
  } event_kind_t;

  typedef struct packed {
    logic [2:0] mod_mode;
    logic       looper_en;
    logic [6:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  held0;
    logic [7:0]  held1;
    logic [1:0]  fill;
    logic [14:0] modulation;
    logic [7:0]  volume;
    logic [7:0]  pitch;
    logic        looper_held;
    logic [6:0]  looper_ticks;
  } state_t;

  typedef struct packed {
    event_kind_t kind;
    logic [6:0]  note;
    logic [7:0]  velocity;
    logic [14:0] modulation;
    logic [7:0]  volume;
    logic [7:0]  pitch;
    logic        looper_active;
  } result_t;

  function automatic logic is_status(input logic [7:0] b);
    return (b == ST_NOTE) || (b == ST_CTRL) || (b == ST_PITCH);
  endfunction

  // Scale a modulation wheel data byte by the selected mode
  function automatic logic [14:0] scale_mod(input logic [2:0] mode, input logic [7:0] mv);
    logic [16:0] prod;
    logic [7:0]  inv;
    logic [14:0] res;
    prod = 17'd0;
    inv  = 8'd0;
    res  = 15'd0;
    unique case (mode)
      3'd1: begin
        prod = 17'(mv) * 17'd25;
        res  = 15'(prod >> 5);
      end
      3'd2: begin
        if (!mv[7]) begin
          inv  = 8'd128 - mv;
          prod = 17'(inv) * 17'd25;
          res  = 15'(prod >> 7) * 15'd1000;
        end
      end
      3'd3: begin
        prod = 17'(mv) * 17'd250;
        res  = 15'(prod >> 7);
      end
      3'd4, 3'd7: begin
        prod = 17'(mv) * 17'd50;
        res  = 15'(prod >> 7);
      end
      3'd5: begin
        prod = 17'(mv) * 17'd70;
        res  = 15'(prod >> 7);
      end
      3'd6: begin
        prod = 17'(mv) * 17'd300;
        res  = 15'(prod >> 7);
      end
      default: res = 15'd0;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mmp_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmp_in_if
// Input channel: one MIDI byte or one tick per transfer.
// ----------------------------------------------------------------------------
interface mmp_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] midi_byte;

  modport source (output valid, output req_type, output midi_byte, input ready);
  modport sink   (input valid, input req_type, input midi_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mmp_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmp_out_if
// Result channel: one parser result per transfer.
// ----------------------------------------------------------------------------
interface mmp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [6:0]  note_number;
  logic [7:0]  note_velocity;
  logic [14:0] modulation_value;
  logic [7:0]  volume_value;
  logic [7:0]  pitch_value;
  logic        looper_active;

  modport source (output valid, output event_kind, output note_number,
                  output note_velocity, output modulation_value,
                  output volume_value, output pitch_value,
                  output looper_active, input ready);
  modport sink   (input valid, input event_kind, input note_number,
                  input note_velocity, input modulation_value,
                  input volume_value, input pitch_value,
                  input looper_active, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mmp_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmp_step
// Next parser state and result for one byte or tick.
// ----------------------------------------------------------------------------
module mmp_step (
  input  wire mmp_pkg::cfg_t   cfg,
  input  wire mmp_pkg::state_t cur,
  input  wire logic            req_type,
  input  wire logic [7:0]      midi_byte,
  output mmp_pkg::state_t      nxt,
  output mmp_pkg::result_t     res
);
  import mmp_pkg::*;

  always_comb begin
    logic [6:0]  ticks_inc;
    event_kind_t kind;
    logic [6:0]  note;
    logic [7:0]  vel;

    nxt       = cur;
    kind      = EV_NONE;
    note      = 7'd0;
    vel       = 8'd0;
    ticks_inc = cur.looper_ticks + 7'd1;

    priority if (req_type == REQ_TICK) begin
      // advance the looper hold, release at the configured count
      if (cur.looper_held) begin
        nxt.looper_ticks = ticks_inc;
        if (ticks_inc >= cfg.hold_ticks) begin
          nxt.looper_ticks = 7'd0;
          nxt.looper_held  = 1'b0;
        end
      end
    end else if (cfg.looper_en) begin
      // drop the byte, start a hold if none is running
      if (!cur.looper_held) begin
        nxt.looper_held  = 1'b1;
        nxt.looper_ticks = 7'd0;
        kind             = EV_LOOPER;
      end
    end else if (cur.fill == 2'd0) begin
      nxt.held0 = midi_byte;
      nxt.fill  = 2'd1;
    end else if (cur.fill == 2'd1) begin
      nxt.held1 = midi_byte;
      nxt.fill  = 2'd2;
    end else begin
      // third byte completes a message
      nxt.fill = 2'd0;
      priority if (cur.held0 == ST_NOTE) begin
        if (cur.held1 <= NOTE_MAX) begin
          note = cur.held1[6:0];
          if (midi_byte == 8'd0) begin
            kind = EV_RELEASE;
          end else begin
            kind = EV_ATTACK;
            vel  = midi_byte;
          end
        end
      end else if (cur.held0 == ST_CTRL) begin
        if (cur.held1 == CC_MOD) begin
          nxt.modulation = scale_mod(cfg.mod_mode, midi_byte);
          kind           = EV_MOD;
        end else if (cur.held1 == CC_VOLUME) begin
          nxt.volume = midi_byte;
          kind       = EV_VOLUME;
        end
      end else if (cur.held0 == ST_PITCH) begin
        if (cur.held1 == PITCH_D1) begin
          nxt.pitch = midi_byte;
          kind      = EV_PITCH;
        end
      end else if (is_status(cur.held1)) begin
        // resync on the second byte, keep both trailing bytes
        nxt.held0 = cur.held1;
        nxt.held1 = midi_byte;
        nxt.fill  = 2'd2;
      end else if (is_status(midi_byte)) begin
        nxt.held0 = midi_byte;
        nxt.fill  = 2'd1;
      end else begin
        // no status behind it: drop all three bytes
        nxt.fill = 2'd0;
      end
    end

    res.kind          = kind;
    res.note          = note;
    res.velocity      = vel;
    res.modulation    = nxt.modulation;
    res.volume        = nxt.volume;
    res.pitch         = nxt.pitch;
    res.looper_active = nxt.looper_held;
  end

endmodule
`default_nettype wire

// ===== rtl/core/midi_message_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// midi_message_parser
// MIDI channel message parser with modulation scaling and looper trigger.
// ----------------------------------------------------------------------------
// Usage:
//   in_port  : one transfer per raw MIDI byte (req_type 0) or tick (req_type 1).
//   out_port : exactly one result per input transfer, in order, carrying the
//              event code and the current modulation, volume, pitch and
//              looper state after that input.
//   cfg_*    : write-only register port (0 mod wheel mode, 1 looper trigger
//              enable, 2 looper hold ticks); write only while idle.
// Each result goes to the output register, or to the skid buffer while that
// register is stalled. Throughput is one item per cycle while out_port.ready
// holds, set by the single combinational step from state to output register.
// A one-entry skid buffer behind the output register keeps in_port.ready
// high while one result waits; ready drops only when both hold results.
// Reset (synchronous, active low) clears the message assembly, sets volume
// to 120, pitch to 64, modulation to 0, releases the looper and restores the
// register defaults; no results are pending afterward.
// ----------------------------------------------------------------------------
module midi_message_parser (
  input  wire logic       clk,
  input  wire logic       rst_n,
  mmp_in_if.sink          in_port,
  mmp_out_if.source       out_port,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_wdata
);
  import mmp_pkg::*;

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t step_res;
  result_t out_r;
  result_t skid_r;
  logic    out_valid_r;
  logic    skid_valid_r;
  logic    in_xfer;
  logic    out_xfer;

  assign in_port.ready = !skid_valid_r;
  assign in_xfer       = in_port.valid && in_port.ready;
  assign out_xfer      = out_valid_r && out_port.ready;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mod_mode   <= 3'd0;
      cfg_r.looper_en  <= 1'b0;
      cfg_r.hold_ticks <= HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MOD_MODE:   cfg_r.mod_mode   <= cfg_wdata[2:0];
        CFG_LOOPER_EN:  cfg_r.looper_en  <= cfg_wdata[0];
        CFG_HOLD_TICKS: cfg_r.hold_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mmp_step u_step (
    .cfg       (cfg_r),
    .cur       (state_r),
    .req_type  (in_port.req_type),
    .midi_byte (in_port.midi_byte),
    .nxt       (state_nxt),
    .res       (step_res)
  );

  // Advance parser state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.held0        <= 8'd0;
      state_r.held1        <= 8'd0;
      state_r.fill         <= 2'd0;
      state_r.modulation   <= 15'd0;
      state_r.volume       <= VOLUME_RST;
      state_r.pitch        <= PITCH_RST;
      state_r.looper_held  <= 1'b0;
      state_r.looper_ticks <= 7'd0;
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  // Output register and skid valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_xfer) begin
        out_valid_r  <= skid_valid_r || in_xfer;
        skid_valid_r <= 1'b0;
      end else if (in_xfer) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Output and skid payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_xfer) begin
      out_r <= skid_valid_r ? skid_r : step_res;
    end else if (in_xfer) begin
      skid_r <= step_res;
    end
  end

  // Drive the result channel
  assign out_port.valid            = out_valid_r;
  assign out_port.event_kind       = out_r.kind;
  assign out_port.note_number      = out_r.note;
  assign out_port.note_velocity    = out_r.velocity;
  assign out_port.modulation_value = out_r.modulation;
  assign out_port.volume_value     = out_r.volume;
  assign out_port.pitch_value      = out_r.pitch;
  assign out_port.looper_active    = out_r.looper_active;

endmodule
`default_nettype wire
